>>> hdl/shuffled_lehmer_random_generator_core_assert.svh
// ---------------------------------------------------------------------------
// shuffled lehmer generator assertion macros
// shared property wrappers, clocked on i_clk and held off during reset
// ---------------------------------------------------------------------------
`ifndef SHUFFLED_LEHMER_RANDOM_GENERATOR_CORE_ASSERT_SVH
`define SHUFFLED_LEHMER_RANDOM_GENERATOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define SLRG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slrg check failed");

// next-cycle implication
`define SLRG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slrg check failed");

`else

`define SLRG_ASSERT_NOW(label, ante, cons)
`define SLRG_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> hdl/slrg_pkg.sv
// ---------------------------------------------------------------------------
// slrg_pkg
// constants and controller/datapath command types of the shuffled lehmer core
// ---------------------------------------------------------------------------
package slrg_pkg;

    localparam int          STATE_W        = 31;
    localparam int          MULT_W         = 15;
    localparam int          PROD_W         = STATE_W + MULT_W;
    localparam int          WARMUP_DISCARD = 8;

    localparam logic [MULT_W-1:0] LCG_MULT = 15'd16807;
    localparam logic [31:0]       LCG_MOD  = 32'h7FFF_FFFF;

    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_RESEED = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic seed_load;
        logic mul;
        logic fold;
        logic cnt_warm;
        logic cnt_dec;
        logic warm_wr;
        logic warm_done;
        logic div_load;
        logic tbl_rd;
        logic commit;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic cnt_zero;
    } t_dp_status;

endpackage

>>> hdl/slrg_datapath.sv
// ---------------------------------------------------------------------------
// slrg_datapath
// generator state, 31x15 multiplier with mersenne fold, table index compare,
// shuffle table memory and output word register
// ---------------------------------------------------------------------------
module slrg_datapath
    import slrg_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    input  logic [STATE_W-1:0]  i_seed_value,
    output logic [STATE_W-1:0]  o_random_value
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + WARMUP_DISCARD);
    localparam logic [31:0]      SHUF_DIV = 32'd1 + (LCG_MOD - 32'd1) / 32'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] WARM_CNT = CNT_W'(TABLE_DEPTH + WARMUP_DISCARD - 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(TABLE_DEPTH);

    logic [STATE_W-1:0] r_gen;
    logic [STATE_W-1:0] r_prev;
    logic [PROD_W-1:0]  r_prod;
    logic [CNT_W-1:0]   r_cnt;
    logic [IDX_W-1:0]   r_quo;
    logic [STATE_W-1:0] r_rd_data;
    logic [STATE_W-1:0] r_out;
    logic [STATE_W-1:0] r_table [TABLE_DEPTH];

    logic [31:0]        w_sum;
    logic [STATE_W-1:0] n_fold;
    logic [IDX_W-1:0]   n_quo;
    logic [IDX_W-1:0]   w_idx;
    logic               w_tbl_we;
    logic [IDX_W-1:0]   w_tbl_waddr;
    logic [STATE_W-1:0] w_tbl_wdata;
    logic [STATE_W-1:0] n_seed;

    // x*16807 mod 2^31-1: fold high bits onto low bits, one correction
    assign w_sum  = {1'b0, r_prod[STATE_W-1:0]} + 32'(r_prod[PROD_W-1:STATE_W]);
    assign n_fold = (w_sum >= LCG_MOD) ? STATE_W'(w_sum - LCG_MOD) : w_sum[STATE_W-1:0];

    assign n_seed = ((i_seed_value == '0) || (i_seed_value == LCG_MOD[STATE_W-1:0]))
                    ? STATE_W'(1) : i_seed_value;

    // index = prev / divisor, the highest constant multiple of the divisor reached
    always_comb begin
        n_quo = '0;
        for (int k = 1; k < TABLE_DEPTH; k++) begin
            if ({1'b0, r_prev} >= 32'(k) * SHUF_DIV) begin
                n_quo = IDX_W'(k);
            end
        end
    end

    assign w_idx = r_quo;

    always_comb begin
        w_tbl_we    = 1'b0;
        w_tbl_waddr = w_idx;
        w_tbl_wdata = r_gen;
        if (i_cmd.warm_wr && (r_cnt < DEPTH_C)) begin
            w_tbl_we    = 1'b1;
            w_tbl_waddr = r_cnt[IDX_W-1:0];
            w_tbl_wdata = n_fold;
        end else if (i_cmd.commit) begin
            w_tbl_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen  <= STATE_W'(1);
            r_prev <= '0;
        end else begin
            if (i_cmd.seed_load) begin
                r_gen <= n_seed;
            end else if (i_cmd.fold) begin
                r_gen <= n_fold;
            end
            if (i_cmd.warm_done) begin
                r_prev <= n_fold;
            end else if (i_cmd.commit) begin
                r_prev <= r_rd_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_gen) * PROD_W'(LCG_MULT);
        end
        if (i_cmd.cnt_warm) begin
            r_cnt <= WARM_CNT;
        end else if (i_cmd.cnt_dec) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
        if (i_cmd.div_load) begin
            r_quo <= n_quo;
        end
        if (i_cmd.commit) begin
            r_out <= r_rd_data;
        end
    end

    // shuffle table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_tbl_we) begin
            r_table[w_tbl_waddr] <= w_tbl_wdata;
        end
        if (i_cmd.tbl_rd) begin
            r_rd_data <= r_table[w_idx];
        end
    end

    assign o_status.cnt_zero = (r_cnt == '0);
    assign o_random_value    = r_out;

endmodule

>>> hdl/slrg_ctrl.sv
// ---------------------------------------------------------------------------
// slrg_ctrl
// sequencer for reseed, warm-up and draw; owns init-pending and output valid
// ---------------------------------------------------------------------------
`include "shuffled_lehmer_random_generator_core_assert.svh"

module slrg_ctrl
    import slrg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output t_dp_cmd     o_cmd,
    input  t_dp_status  i_status
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b000_0001,
        S_WMUL  = 7'b000_0010,
        S_WFOLD = 7'b000_0100,
        S_MUL   = 7'b000_1000,
        S_FOLD  = 7'b001_0000,
        S_READ  = 7'b010_0000,
        S_WRITE = 7'b100_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_pending, n_pending;
    logic   r_out_valid;
    logic   w_accept;
    logic   w_out_free;
    logic   w_draw_acc;
    logic   w_reseed_acc;

    assign o_in_stall   = (r_state != S_IDLE);
    assign w_accept     = i_in_valid && !o_in_stall;
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_draw_acc   = w_accept && (i_command == CMD_DRAW);
    assign w_reseed_acc = w_accept && (i_command == CMD_RESEED);

    always_comb begin
        n_state   = r_state;
        n_pending = r_pending;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_command == CMD_RESEED) begin
                        o_cmd.seed_load = 1'b1;
                        n_pending       = 1'b1;
                    end else if (r_pending) begin
                        o_cmd.cnt_warm = 1'b1;
                        n_state        = S_WMUL;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_WMUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_WFOLD;
            end
            S_WFOLD: begin
                o_cmd.fold    = 1'b1;
                o_cmd.warm_wr = 1'b1;
                if (i_status.cnt_zero) begin
                    o_cmd.warm_done = 1'b1;
                    n_pending       = 1'b0;
                    n_state         = S_MUL;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_WMUL;
                end
            end
            S_MUL: begin
                o_cmd.mul      = 1'b1;
                o_cmd.div_load = 1'b1;
                n_state        = S_FOLD;
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                n_state    = S_READ;
            end
            S_READ: begin
                o_cmd.tbl_rd = 1'b1;
                n_state      = S_WRITE;
            end
            S_WRITE: begin
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pending   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    `SLRG_ASSERT_NEXT(a_warm_on_pending, w_draw_acc && r_pending, r_state == S_WMUL)
    `SLRG_ASSERT_NEXT(a_warm_clears_pending, (r_state == S_WFOLD) && i_status.cnt_zero, !r_pending)
    `SLRG_ASSERT_NOW(a_no_overwrite, o_cmd.commit, !r_out_valid || !i_out_stall)
    `SLRG_ASSERT_NEXT(a_reseed_sets_pending, w_reseed_acc, r_pending && (r_state == S_IDLE))

endmodule

>>> hdl/shuffled_lehmer_random_generator_core.sv
// ---------------------------------------------------------------------------
// shuffled_lehmer_random_generator_core
// minimal-standard lehmer generator with a bays-durham shuffle table
// ---------------------------------------------------------------------------
// draw: multiply with index load, fold, table read and write-back, each in its own state;
//   the next item is taken once the write-back is done and the core is idle again
// a stalled output word holds the next draw in its write-back step
// first draw after reset or reseed adds warm-up: WARMUP_DISCARD steps, then a table fill
// reseed: taken in idle, the core stays idle, no output word
// reset (sync, active low) acts as seed one with warm-up pending; table needs no clear
module shuffled_lehmer_random_generator_core
    import slrg_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input word channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_command,
    input  logic [STATE_W-1:0]  i_seed_value,
    // output word channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATE_W-1:0]  o_random_value
);

    // command and status between sequencer and datapath
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // sequencer: idle/accept, warm-up loop, draw steps, output handoff
    slrg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    // generator arithmetic, table index, shuffle table and output register
    slrg_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_seed_value   (i_seed_value),
        .o_random_value (o_random_value)
    );

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the shuffled lehmer generator: a short table of
// directed draws and reseeds, then random traffic over four idling phases,
// every output word compared against an in-bench shuffle-table predictor
// ---------------------------------------------------------------------------
module tb_top;
    import slrg_pkg::*;

    localparam int TABLE_DEPTH = 32;
    // index divisor, 2^26 for a 32-entry table
    localparam logic [31:0] SHUFFLE_DIV = 1 + (LCG_MOD - 1) / TABLE_DEPTH;
    localparam int RANDOM_WORDS = 1880;
    localparam int PHASES       = 4;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic                i_command = CMD_DRAW;
    logic [STATE_W-1:0]  i_seed_value = '0;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [STATE_W-1:0]  o_random_value;

    shuffled_lehmer_random_generator_core #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_seed_value   (i_seed_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_random_value (o_random_value)
    );

    always #5 i_clk = ~i_clk;

    // predictor state, mirrors the generator, the shuffle table and the last output
    logic [STATE_W-1:0] gen_state;
    logic [STATE_W-1:0] shuf_tbl [TABLE_DEPTH];
    logic [STATE_W-1:0] last_out;
    bit                 warm_pending;

    // draws predicted but not yet seen on the output side, oldest first
    logic [STATE_W-1:0] pending_draws [$];

    int mismatch_count = 0;
    int words_checked  = 0;
    int draws_sent     = 0;
    int reseeds_sent   = 0;

    // idling knobs shared with the receiver process
    int stall_pct = 0;
    int hold_req  = 0;

    // one row of the directed table; word marks rows that must yield an output word
    typedef struct packed {
        logic               cmd;
        logic [STATE_W-1:0] seed;
        logic               word;
    } t_step_row;

    // no draw value can be read off directly, so every draw goes through the predictor
    t_step_row directed_rows [20] = '{
        '{CMD_DRAW,   31'd0,          1'b1},  // first draw after reset, warm-up from seed one
        '{CMD_DRAW,   31'h7FFF_FFFF,  1'b1},  // seed field is ignored on a draw
        '{CMD_DRAW,   31'd0,          1'b1},
        '{CMD_RESEED, 31'd0,          1'b0},  // zero seed, state becomes one
        '{CMD_DRAW,   31'd0,          1'b1},
        '{CMD_DRAW,   31'd0,          1'b1},
        '{CMD_RESEED, 31'h7FFF_FFFF,  1'b0},  // seed equal to the modulus, treated as zero
        '{CMD_DRAW,   31'd0,          1'b1},
        '{CMD_RESEED, 31'h7FFF_FFFE,  1'b0},  // largest legal seed
        '{CMD_DRAW,   31'd0,          1'b1},
        '{CMD_DRAW,   31'd0,          1'b1},
        '{CMD_RESEED, 31'd1234,       1'b0},  // back-to-back reseeds, the last one wins
        '{CMD_RESEED, 31'h2AAA_AAAA,  1'b0},
        '{CMD_DRAW,   31'd0,          1'b1},
        '{CMD_RESEED, 31'h5555_5555,  1'b0},
        '{CMD_DRAW,   31'd0,          1'b1},
        '{CMD_RESEED, 31'd1,          1'b0},  // smallest legal seed
        '{CMD_DRAW,   31'd0,          1'b1},
        '{CMD_DRAW,   31'd0,          1'b1},
        '{CMD_DRAW,   31'h2AAA_AAAA,  1'b1}
    };

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // one minimal-standard step, x * 16807 mod (2^31 - 1)
    function automatic logic [STATE_W-1:0] lehmer_next(input logic [STATE_W-1:0] x);
        logic [63:0] prod;
        prod = 64'(x) * 64'(LCG_MULT);
        return STATE_W'(prod % 64'(LCG_MOD));
    endfunction

    // advance the predictor by one accepted word; a draw yields one output word
    task automatic shuffle_predict(input logic cmd, input logic [STATE_W-1:0] seed,
                                   output bit has_word, output logic [STATE_W-1:0] value);
        int                 idx;
        logic [STATE_W-1:0] s;
        has_word = 1'b0;
        value    = '0;
        if (cmd == CMD_RESEED) begin
            s = seed;
            // zero and the modulus itself would lock the generator at zero
            if (s == '0 || {1'b0, s} == LCG_MOD)
                s = STATE_W'(1);
            gen_state    = s;
            warm_pending = 1'b1;
        end else begin
            if (warm_pending) begin
                // discard the first steps, then fill the table from the top entry down
                for (int n = TABLE_DEPTH + WARMUP_DISCARD - 1; n >= 0; n--) begin
                    gen_state = lehmer_next(gen_state);
                    if (n < TABLE_DEPTH)
                        shuf_tbl[n] = gen_state;
                end
                last_out     = shuf_tbl[0];
                warm_pending = 1'b0;
            end
            gen_state = lehmer_next(gen_state);
            idx = int'({1'b0, last_out} / SHUFFLE_DIV);
            if (idx >= TABLE_DEPTH)
                idx = TABLE_DEPTH - 1;
            last_out      = shuf_tbl[idx];
            shuf_tbl[idx] = gen_state;
            has_word      = 1'b1;
            value         = last_out;
        end
    endtask

    // offer one word, with random idle cycles before it; returns after acceptance
    // at the following falling edge, so the next word can follow without a gap
    task automatic send_word(input logic cmd, input logic [STATE_W-1:0] seed,
                             input int idle_pct, output bit has_word);
        logic [STATE_W-1:0] value;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_seed_value <= seed;
        do
            @(posedge i_clk);
        while (o_in_stall);
        shuffle_predict(cmd, seed, has_word, value);
        if (has_word) begin
            pending_draws.push_back(value);
            draws_sent++;
        end else begin
            reseeds_sent++;
        end
        @(negedge i_clk);
    endtask

    // random seed, mostly full-width noise, now and then an extreme
    function automatic logic [STATE_W-1:0] pick_seed();
        case ($urandom_range(19))
            0:       return '0;
            1:       return 31'h7FFF_FFFF;
            2:       return 31'h7FFF_FFFE;
            3:       return 31'd1;
            default: return STATE_W'($urandom);
        endcase
    endfunction

    // receiver side: random stalls, plus a long counted hold-off on request
    initial begin
        int hold_left;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (!i_rst_n) begin
                i_out_stall <= 1'b0;
            end else if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // output checker, every accepted word against the oldest predicted draw
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_draws.size() == 0) begin
                report_mismatch($sformatf("unexpected word %0d", o_random_value));
            end else begin
                if (o_random_value !== pending_draws[0])
                    report_mismatch($sformatf("random_value %0d, predicted %0d",
                                              o_random_value, pending_draws[0]));
                void'(pending_draws.pop_front());
                words_checked++;
            end
        end
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #(10_000_000);
        $display("status: fail");
        $finish;
    end

    initial begin
        // idle percentages per phase: none, sender only, receiver only, both
        int                 idle_by_phase  [PHASES];
        int                 stall_by_phase [PHASES];
        bit                 has_word;
        logic               cmd;
        logic [STATE_W-1:0] seed;
        int                 per_phase;

        idle_by_phase  = '{0, 66, 0, 27};
        stall_by_phase = '{0, 0, 66, 27};

        // predictor reset, seed one with warm-up pending
        gen_state    = STATE_W'(1);
        last_out     = '0;
        warm_pending = 1'b1;
        foreach (shuf_tbl[i])
            shuf_tbl[i] = '0;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        foreach (directed_rows[r]) begin
            send_word(directed_rows[r].cmd, directed_rows[r].seed, 0, has_word);
            if (has_word != directed_rows[r].word)
                report_mismatch($sformatf("directed row %0d yields word %0b", r, has_word));
        end

        // random part: mostly draws, reseeds sprinkled in so warm-ups recur
        per_phase = RANDOM_WORDS / PHASES;
        for (int ph = 0; ph < PHASES; ph++) begin
            stall_pct = stall_by_phase[ph];
            for (int k = 0; k < per_phase; k++) begin
                // long receiver hold-off while words keep coming, fills the core
                if (ph == 0 && k == 60)
                    hold_req = 300;
                cmd  = ($urandom_range(99) < 8) ? CMD_RESEED : CMD_DRAW;
                seed = pick_seed();
                send_word(cmd, seed, idle_by_phase[ph], has_word);
            end
        end
        i_in_valid <= 1'b0;

        // drain, then let the core settle
        while (pending_draws.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("run covered %0d draws and %0d reseeds over %0d idling phases",
                 draws_sent, reseeds_sent, PHASES);
        $display("%0d words checked, %0d mismatches", words_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
